### rtl/tpspwm_pkg.sv
// ----------------------------------------------------------------------------
// tpspwm_pkg
// Shared constants and types for the three-phase sine PWM duty generator.
// ----------------------------------------------------------------------------
package tpspwm_pkg;

    // Sine table geometry
    localparam int TABLE_INDEX_BITS = 10;
    localparam int ROM_DEPTH        = 1 << TABLE_INDEX_BITS;
    localparam int QUARTER          = ROM_DEPTH / 4;

    // Phase offsets of phases B and C: one third and two thirds of a turn
    localparam logic [31:0] OFFSET_B = 32'h5555_5555;
    localparam logic [31:0] OFFSET_C = 32'hAAAA_AAAA;

    // pi/2 in Q62, seed of the table build
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // Configuration register defaults and limits
    localparam logic [14:0] MID_RESET = 15'd50;
    localparam logic [9:0]  MOD_MAX   = 10'd1000;

    // swing = floor(mid * mod / 1000) through a reciprocal multiply.
    // The product stays below 2^25, where this reciprocal is exact.
    localparam int          PROD_W      = 25;
    localparam int          SWING_DIV   = 1000;
    localparam int          SWING_SHIFT = 35;
    localparam int          RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] SWING_RECIP =
        RECIP_W'(((64'd1 << SWING_SHIFT) + 64'(SWING_DIV) - 64'd1) / 64'(SWING_DIV));

    // Sample scaling: product of swing and Q15 sample, shifted right by 15
    localparam int Q_SHIFT = 15;

    typedef logic signed [15:0]         t_sample;
    typedef logic [15:0]                t_duty;
    typedef logic [31:0]                t_word;
    typedef logic [TABLE_INDEX_BITS-1:0] t_rom_addr;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MID_SCALE  = 2'd0,
        REG_MODULATION = 2'd1,
        REG_PHASE_INC  = 2'd2
    } t_reg_idx;

endpackage

### rtl/tpspwm_in_if.sv
// ----------------------------------------------------------------------------
// tpspwm_in_if
// Input channel: one PWM update event per item.
// ----------------------------------------------------------------------------
interface tpspwm_in_if;
    import tpspwm_pkg::*;

    logic  valid;
    logic  ready;
    t_word timestamp;
    logic  clear_stats;

    modport source (output valid, output timestamp, output clear_stats, input ready);
    modport sink   (input valid, input timestamp, input clear_stats, output ready);

endinterface

### rtl/tpspwm_out_if.sv
// ----------------------------------------------------------------------------
// tpspwm_out_if
// Output channel: three compare values and the update statistics.
// ----------------------------------------------------------------------------
interface tpspwm_out_if;
    import tpspwm_pkg::*;

    logic  valid;
    logic  ready;
    t_duty duty_a;
    t_duty duty_b;
    t_duty duty_c;
    t_word update_count;
    t_word interval_min;
    t_word interval_max;

    modport source (
        output valid, output duty_a, output duty_b, output duty_c,
        output update_count, output interval_min, output interval_max,
        input  ready
    );
    modport sink (
        input  valid, input duty_a, input duty_b, input duty_c,
        input  update_count, input interval_min, input interval_max,
        output ready
    );

endinterface

### rtl/tpspwm_sine_rom.sv
// ----------------------------------------------------------------------------
// tpspwm_sine_rom
// Q15 sine table, round(32767*sin(2*pi*i/depth)), with a registered read.
// ----------------------------------------------------------------------------
module tpspwm_sine_rom (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  tpspwm_pkg::t_rom_addr i_addr,
    output tpspwm_pkg::t_sample   o_data
);
    import tpspwm_pkg::*;

    typedef t_sample t_rom [ROM_DEPTH];

    // Reciprocals of the series divisors (n-1)*n for n = 3, 5, ..., 29,
    // ceil(2^74 / d); exact for any 64-bit dividend since every d < 2^10
    localparam int                RECIP_SHIFT = 74;
    localparam logic [79:0]       RECIP_ONE   = 80'd1 << RECIP_SHIFT;
    localparam logic [13:0][71:0] TERM_RECIP  = {
        72'((RECIP_ONE + 80'd811) / 80'd812),
        72'((RECIP_ONE + 80'd701) / 80'd702),
        72'((RECIP_ONE + 80'd599) / 80'd600),
        72'((RECIP_ONE + 80'd505) / 80'd506),
        72'((RECIP_ONE + 80'd419) / 80'd420),
        72'((RECIP_ONE + 80'd341) / 80'd342),
        72'((RECIP_ONE + 80'd271) / 80'd272),
        72'((RECIP_ONE + 80'd209) / 80'd210),
        72'((RECIP_ONE + 80'd155) / 80'd156),
        72'((RECIP_ONE + 80'd109) / 80'd110),
        72'((RECIP_ONE + 80'd71) / 80'd72),
        72'((RECIP_ONE + 80'd41) / 80'd42),
        72'((RECIP_ONE + 80'd19) / 80'd20),
        72'((RECIP_ONE + 80'd5) / 80'd6)
    };

    // floor(a*b / 2^62)
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Rounded quarter-wave sample from a fixed-point Taylor series
    function automatic t_sample quarter_sine(input int unsigned k);
        logic [63:0]  kk;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [143:0] pq;
        logic [63:0]  v;
        kk   = 64'(k);
        x    = (HALF_PI_Q62 / 64'(QUARTER)) * kk
             + ((HALF_PI_Q62 % 64'(QUARTER)) * kk) / 64'(QUARTER);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 3; n <= 29; n += 2) begin
            pq   = 144'(mul_q62(term, x2)) * 144'(TERM_RECIP[(n - 3) >> 1]);
            term = pq[RECIP_SHIFT +: 64];
            if ((((n - 1) >> 1) & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (64'd32767 * (sum >> 22) + (64'd1 << 39)) >> 40;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return t_sample'(v[15:0]);
    endfunction

    function automatic t_rom build_rom();
        t_rom        r;
        int unsigned q;
        int unsigned k;
        t_sample     s;
        for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
            q = i / QUARTER;
            k = i % QUARTER;
            s = ((q & 1) != 0) ? quarter_sine(QUARTER - k) : quarter_sine(k);
            r[i] = ((q & 2) != 0) ? -s : s;
        end
        return r;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### rtl/three_phase_sine_pwm_duty.sv
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_duty
// Three-phase sine PWM compare generator with update interval statistics.
// Each item moves through the accept, table read, multiply and output
//   register stages in order.
// Throughput: one item per cycle; the four pipeline stages and the three
//   sine table read ports advance together and freeze while a result waits.
// Swing follows a configuration write through the product and swing registers.
// Reset (synchronous, active low) restores the register defaults and clears
//   the phase, statistics and pipeline valid bits.
// ----------------------------------------------------------------------------
module three_phase_sine_pwm_duty (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  tpspwm_pkg::t_word    i_cfg_data,
    tpspwm_in_if.sink            i_in,
    tpspwm_out_if.source         o_out
);
    import tpspwm_pkg::*;

    // Configuration registers
    logic [14:0]       r_mid;
    logic [9:0]        r_mod;
    t_word             r_inc;
    logic [PROD_W-1:0] r_prod;
    logic [15:0]       r_swing;

    // Running state
    t_word r_phase;
    t_word r_prev;
    logic  r_prev_v;
    t_word r_min;
    logic  r_seen;
    t_word r_max;
    t_word r_cnt;

    // Pipeline valid bits
    logic r_a_v, r_b_v, r_c_v, r_d_v;

    // Stage payloads
    t_word         r_a_phase;
    t_word         r_a_cnt, r_a_min, r_a_max;
    t_word         r_b_cnt, r_b_min, r_b_max;
    t_word         r_c_cnt, r_c_min, r_c_max;
    logic [31:0]   r_c_pa, r_c_pb, r_c_pc;
    t_duty         r_d_da, r_d_db, r_d_dc;
    t_word         r_d_cnt, r_d_min, r_d_max;

    logic adv;
    logic acc;

    // Hold the whole pipe while the output register is full and not taken
    assign adv         = !r_d_v || o_out.ready;
    assign i_in.ready  = adv;
    assign acc         = i_in.valid && adv;

    // ---- Interval statistics for the incoming item ----
    t_word d_int;
    logic  upd_min;
    t_word n_min;
    logic  n_seen;
    t_word n_max;
    t_word n_cnt;
    t_word n_phase;

    always_comb begin
        d_int   = i_in.timestamp - r_prev;
        upd_min = r_prev_v && (!r_seen || d_int < r_min);
        n_min   = upd_min ? d_int : r_min;
        n_seen  = r_seen || r_prev_v;
        n_max   = (r_prev_v && d_int > r_max) ? d_int : r_max;
        n_cnt   = r_cnt + 32'd1;
        n_phase = r_phase + r_inc;
    end

    // ---- Sine table reads, one port per phase ----
    t_word     ph_b, ph_c;
    t_sample   s_a, s_b, s_c;
    t_rom_addr addr_a, addr_b, addr_c;

    always_comb begin
        ph_b   = r_a_phase + OFFSET_B;
        ph_c   = r_a_phase + OFFSET_C;
        addr_a = r_a_phase[31 -: TABLE_INDEX_BITS];
        addr_b = ph_b[31 -: TABLE_INDEX_BITS];
        addr_c = ph_c[31 -: TABLE_INDEX_BITS];
    end

    tpspwm_sine_rom u_rom_a (.i_clk(i_clk), .i_en(adv), .i_addr(addr_a), .o_data(s_a));
    tpspwm_sine_rom u_rom_b (.i_clk(i_clk), .i_en(adv), .i_addr(addr_b), .o_data(s_b));
    tpspwm_sine_rom u_rom_c (.i_clk(i_clk), .i_en(adv), .i_addr(addr_c), .o_data(s_c));

    // ---- Multiply and offset ----
    logic signed [16:0] swing_s;
    logic signed [32:0] n_pa, n_pb, n_pc;
    logic [16:0]        sum_a, sum_b, sum_c;
    logic [50:0]        swing_full;

    always_comb begin
        swing_s    = $signed({1'b0, r_swing});
        n_pa       = swing_s * s_a;
        n_pb       = swing_s * s_b;
        n_pc       = swing_s * s_c;
        // Arithmetic shift by 15 keeps 17 bits; add in two's complement mod 2^17
        sum_a      = {2'b00, r_mid} + r_c_pa[31:Q_SHIFT];
        sum_b      = {2'b00, r_mid} + r_c_pb[31:Q_SHIFT];
        sum_c      = {2'b00, r_mid} + r_c_pc[31:Q_SHIFT];
        swing_full = 51'(r_prod) * 51'(SWING_RECIP);
    end

    // ---- Control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= MID_RESET;
            r_mod    <= '0;
            r_inc    <= '0;
            r_prod   <= '0;
            r_swing  <= '0;
            r_phase  <= '0;
            r_prev   <= '0;
            r_prev_v <= 1'b0;
            r_min    <= '1;
            r_seen   <= 1'b0;
            r_max    <= '0;
            r_cnt    <= '0;
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
        end else begin
            // Register writes; unknown index is dropped
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MID_SCALE: begin
                        r_mid <= i_cfg_data[14:0];
                    end
                    REG_MODULATION: begin
                        r_mod <= (i_cfg_data[9:0] > MOD_MAX) ? MOD_MAX : i_cfg_data[9:0];
                    end
                    REG_PHASE_INC: begin
                        r_inc <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            // Swing follows the registers through two multiply stages
            r_prod  <= PROD_W'(r_mid * r_mod);
            r_swing <= swing_full[SWING_SHIFT +: 16];

            // Advance phase and statistics on every accepted item
            if (acc) begin
                r_phase  <= n_phase;
                r_prev   <= i_in.timestamp;
                r_prev_v <= 1'b1;
                if (i_in.clear_stats) begin
                    r_cnt  <= '0;
                    r_min  <= '1;
                    r_seen <= 1'b0;
                    r_max  <= '0;
                end else begin
                    r_cnt  <= n_cnt;
                    r_min  <= n_min;
                    r_seen <= n_seen;
                    r_max  <= n_max;
                end
            end

            if (adv) begin
                r_a_v <= i_in.valid;
                r_b_v <= r_a_v;
                r_c_v <= r_b_v;
                r_d_v <= r_c_v;
            end
        end
    end

    // ---- Pipeline payload ----
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_phase <= n_phase;
            r_a_cnt   <= n_cnt;
            r_a_min   <= n_seen ? n_min : '0;
            r_a_max   <= n_max;

            r_b_cnt   <= r_a_cnt;
            r_b_min   <= r_a_min;
            r_b_max   <= r_a_max;

            r_c_pa    <= n_pa[31:0];
            r_c_pb    <= n_pb[31:0];
            r_c_pc    <= n_pc[31:0];
            r_c_cnt   <= r_b_cnt;
            r_c_min   <= r_b_min;
            r_c_max   <= r_b_max;

            r_d_da    <= sum_a[15:0];
            r_d_db    <= sum_b[15:0];
            r_d_dc    <= sum_c[15:0];
            r_d_cnt   <= r_c_cnt;
            r_d_min   <= r_c_min;
            r_d_max   <= r_c_max;
        end
    end

    assign o_out.valid        = r_d_v;
    assign o_out.duty_a       = r_d_da;
    assign o_out.duty_b       = r_d_db;
    assign o_out.duty_c       = r_d_dc;
    assign o_out.update_count = r_d_cnt;
    assign o_out.interval_min = r_d_min;
    assign o_out.interval_max = r_d_max;

    // ---- Assertions ----
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.clear_stats |=> r_cnt == '0)
        else $error("update counter not cleared after a clearing item");

    a_min_unseen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> r_min == '1)
        else $error("minimum interval holds a value with no interval recorded");

    a_mod_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod <= MOD_MAX)
        else $error("modulation depth above saturation limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v && !adv |=> r_c_v && $stable(r_c_pa))
        else $error("pipeline stage moved during an output stall");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_a_v)
        else $error("accepted item missing from first stage");

endmodule

### tb/three_phase_sine_pwm_duty_test.sv
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_duty_test
// Self-checking bench for the three-phase sine PWM duty generator. A
// scoreboard keeps its own phase accumulator, sine table and interval
// statistics. It predicts every report from the accepted update items and
// checks each report field by field as it leaves the block. The stimulus
// starts with directed register extremes and update events. Random phases
// follow, each with its own register settings, timestamps, sender bursts
// and receiver stalls.
// ----------------------------------------------------------------------------
module three_phase_sine_pwm_duty_test;
    import tpspwm_pkg::*;

    localparam int          CLK_PERIOD      = 20;
    localparam int          RESET_CYCLES    = 6;
    localparam int          ITEM_TARGET     = 1050;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          PIPE_SLACK      = 6;
    localparam int          TIMEOUT_CYCLES  = 400000;
    // Index past the last register; the block must ignore writes to it
    localparam logic [1:0]  REG_SPARE       = 2'd3;

    // One report as it leaves the block
    typedef struct packed {
        t_duty duty_a;
        t_duty duty_b;
        t_duty duty_c;
        t_word update_count;
        t_word interval_min;
        t_word interval_max;
    } t_pwm_report;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the compare values and statistics of each update
    // and holds them until the matching report comes out.
    // ------------------------------------------------------------------------
    class duty_scoreboard;
        t_sample     sine_table [ROM_DEPTH];
        logic [14:0] mid_scale;
        logic [9:0]  depth;
        t_word       phase_inc;
        logic [15:0] swing;
        t_word       phase_acc;
        t_word       last_stamp;
        bit          stamp_seen;
        t_word       shortest;
        bit          shortest_seen;
        t_word       longest;
        t_word       updates;
        t_pwm_report expected_reports [$];
        int          fails;

        function new();
            int      quad;
            int      k;
            t_sample s;
            // Build the full table from one quarter wave, mirrored and negated
            for (int i = 0; i < ROM_DEPTH; i++) begin
                quad = i / QUARTER;
                k    = i % QUARTER;
                s    = (quad % 2 == 1) ? quarter_sine(QUARTER - k) : quarter_sine(k);
                sine_table[i] = (quad >= 2) ? -s : s;
            end
            mid_scale     = MID_RESET;
            depth         = '0;
            phase_inc     = '0;
            swing         = '0;
            phase_acc     = '0;
            last_stamp    = '0;
            stamp_seen    = 1'b0;
            shortest      = '1;
            shortest_seen = 1'b0;
            longest       = '0;
            updates       = '0;
            fails         = 0;
        endfunction

        // floor(a * b / 2^62)
        function bit [63:0] mul_q62(bit [63:0] a, bit [63:0] b);
            bit [127:0] prod;
            prod = {64'd0, a} * {64'd0, b};
            return prod[125:62];
        endfunction

        // round(32767 * sin(pi/2 * k / QUARTER)) by a Q62 Taylor series
        function t_sample quarter_sine(int k);
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] term;
            bit [63:0] sum;
            bit [63:0] v;
            bit [63:0] qtr;
            bit [63:0] kk;
            qtr  = 64'(QUARTER);
            kk   = 64'(k);
            x    = (HALF_PI_Q62 / qtr) * kk + ((HALF_PI_Q62 % qtr) * kk) / qtr;
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            for (int n = 3; n <= 29; n += 2) begin
                term = mul_q62(term, x2) / 64'((n - 1) * n);
                if (((n - 1) / 2) % 2 == 1) begin
                    sum -= term;
                end else begin
                    sum += term;
                end
            end
            v = (64'd32767 * (sum >> 22) + (64'd1 << 39)) >> 40;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            return t_sample'(v[15:0]);
        endfunction

        // mid + floor(swing * sample / 2^15), kept to 16 bits
        function t_duty duty_at(t_word ph);
            longint prod;
            prod = longint'(swing) * longint'(sine_table[ph[31 -: TABLE_INDEX_BITS]]);
            return t_duty'(longint'(mid_scale) + (prod >>> Q_SHIFT));
        endfunction

        function void write_reg(logic [1:0] idx, t_word data);
            case (idx)
                REG_MID_SCALE:  mid_scale  = data[14:0];
                REG_MODULATION: depth      = (data[9:0] > MOD_MAX) ? MOD_MAX : data[9:0];
                REG_PHASE_INC:  phase_inc  = data;
                default:        return;
            endcase
            swing = 16'((32'(mid_scale) * 32'(depth)) / SWING_DIV);
        endfunction

        function void note_update(t_word stamp, logic clear);
            t_word       gap;
            t_pwm_report rep;
            if (stamp_seen) begin
                gap = stamp - last_stamp;
                if (!shortest_seen || gap < shortest) begin
                    shortest      = gap;
                    shortest_seen = 1'b1;
                end
                if (gap > longest) begin
                    longest = gap;
                end
            end
            last_stamp = stamp;
            stamp_seen = 1'b1;
            phase_acc += phase_inc;
            updates++;
            rep.duty_a       = duty_at(phase_acc);
            rep.duty_b       = duty_at(phase_acc + OFFSET_B);
            rep.duty_c       = duty_at(phase_acc + OFFSET_C);
            rep.update_count = updates;
            rep.interval_min = shortest_seen ? shortest : '0;
            rep.interval_max = longest;
            expected_reports.push_back(rep);
            // The clear takes effect after this report; the last stamp stays
            if (clear) begin
                updates       = '0;
                shortest      = '1;
                shortest_seen = 1'b0;
                longest       = '0;
            end
        endfunction

        function void check_field(string field, t_word want, t_word got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fails++;
            end
        endfunction

        function void check_result(t_pwm_report got);
            t_pwm_report want;
            if (expected_reports.size() == 0) begin
                $error("report item with no update pending");
                fails++;
                return;
            end
            want = expected_reports.pop_front();
            check_field("duty_a", want.duty_a, got.duty_a);
            check_field("duty_b", want.duty_b, got.duty_b);
            check_field("duty_c", want.duty_c, got.duty_c);
            check_field("update_count", want.update_count, got.update_count);
            check_field("interval_min", want.interval_min, got.interval_min);
            check_field("interval_max", want.interval_max, got.interval_max);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    t_word       i_cfg_data;

    tpspwm_in_if  in_ch();
    tpspwm_out_if out_ch();

    duty_scoreboard board;
    int             items_sent   = 0;
    t_word          stamp_now;
    // Count of long hold-offs asked of the receiver
    int             hold_off_req = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    three_phase_sine_pwm_duty u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one update item and hold it until the block takes it. Valid stays
    // high on return; the caller drops it when the burst ends.
    task automatic send_update(t_word stamp, logic clear);
        in_ch.valid       <= 1'b1;
        in_ch.timestamp   <= stamp;
        in_ch.clear_stats <= clear;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_update(stamp, clear);
        items_sent++;
    endtask

    // Write one register. The write enable stays high for back-to-back
    // writes; the caller drops it after the last one.
    task automatic write_reg(logic [1:0] idx, t_word data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Wait until every report has come out, then let the pipeline drain so
    // a register write cannot land on work in flight.
    task automatic settle();
        while (board.expected_reports.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // Mostly steady update spacing, with duplicates, tiny gaps, wraps and
    // the odd jump anywhere in the 32-bit range.
    function automatic t_word advance_stamp();
        case ($urandom_range(0, 19))
            0:       stamp_now = $urandom();
            1:       stamp_now += $urandom();
            2, 3:    stamp_now += $urandom_range(0, 3);
            default: stamp_now += $urandom_range(1, 4000);
        endcase
        return stamp_now;
    endfunction

    // Pick a new setting for some of the registers, extremes included
    task automatic randomize_config();
        t_word data;
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 4))
                0:       data = 32'd0;
                1:       data = 32'h0000_7FFF;
                2:       data = $urandom_range(0, 49);
                default: data = $urandom();
            endcase
            write_reg(REG_MID_SCALE, data);
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
                0:       data = 32'd0;
                1:       data = 32'(MOD_MAX);
                2:       data = $urandom_range(1001, 1023);
                3:       data = $urandom();
                default: data = $urandom_range(0, 1000);
            endcase
            write_reg(REG_MODULATION, data);
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 4))
                0:       data = 32'd0;
                1:       data = 32'hFFFF_FFFF;
                2:       data = $urandom_range(0, 32'h00FF_FFFF);
                default: data = $urandom();
            endcase
            write_reg(REG_PHASE_INC, data);
        end
        if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_SPARE, $urandom());
        end
        i_cfg_we <= 1'b0;
    endtask

    // Send a run of updates in bursts with random gaps, or back to back
    // when steady is set. Drop valid at the end.
    task automatic run_burst(int count, bit steady);
        int burst_left;
        burst_left = $urandom_range(1, 16);
        repeat (count) begin
            send_update(advance_stamp(), $urandom_range(0, 15) == 0);
            burst_left--;
            if (!steady && burst_left == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Report receiver: cycles through always-ready, random and periodic stall
    // patterns, and holds off for a long stretch when asked.
    // ------------------------------------------------------------------------
    initial begin : report_sink
        int cyc;
        int held;
        int holds_done;
        out_ch.ready <= 1'b0;
        cyc        = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_off_req != holds_done) begin
                // Hold ready low so the pipeline fills and stalls its input
                out_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge i_clk);
                holds_done++;
            end
            case ((cyc / 96) % 4)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (cyc % 7 != 3);
            endcase
        end
    end

    // Check every report the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            board.check_result({out_ch.duty_a, out_ch.duty_b, out_ch.duty_c,
                                out_ch.update_count, out_ch.interval_min,
                                out_ch.interval_max});
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_no;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_MID_SCALE;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.timestamp   <= '0;
        in_ch.clear_stats <= 1'b0;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: flat fifty-count duty. First update has no
        // interval, the next one spans the whole 32-bit range, the third
        // wraps and clears, the fourth repeats its stamp for a zero interval.
        send_update(32'd0, 1'b0);
        send_update(32'hFFFF_FFFF, 1'b0);
        send_update(32'd4, 1'b1);
        send_update(32'd4, 1'b0);
        in_ch.valid <= 1'b0;
        settle();

        // Full scale: mid masked down from all ones, modulation saturated,
        // quarter-turn steps land on the sine peaks and zero crossings.
        // The spare index must change nothing.
        write_reg(REG_MID_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_MODULATION, 32'h0000_03FF);
        write_reg(REG_PHASE_INC, 32'h4000_0000);
        write_reg(REG_SPARE, $urandom());
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 5; i++) begin
            send_update(32'd1000 + 32'd100 * i, i == 4);
        end
        in_ch.valid <= 1'b0;
        settle();

        // Zero mid scale with a backward full-range step
        write_reg(REG_MID_SCALE, 32'd0);
        write_reg(REG_MODULATION, 32'd500);
        write_reg(REG_PHASE_INC, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_update(32'd2000, 1'b0);
        send_update(32'd1999, 1'b0);
        send_update(32'd2001, 1'b1);
        in_ch.valid <= 1'b0;
        settle();

        // Mid below its usual range at full depth, one table entry per step
        write_reg(REG_MID_SCALE, 32'd49);
        write_reg(REG_MODULATION, 32'(MOD_MAX));
        write_reg(REG_PHASE_INC, 32'h0040_0000);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 5; i++) begin
            send_update(32'hFFFF_FF00 + 32'h60 * i, 1'b0);
        end
        in_ch.valid <= 1'b0;
        settle();

        // Half-turn steps at minimal depth
        write_reg(REG_MID_SCALE, 32'd16384);
        write_reg(REG_MODULATION, 32'd1);
        write_reg(REG_PHASE_INC, 32'h8000_0000);
        i_cfg_we <= 1'b0;
        send_update(32'h8000_0000, 1'b0);
        send_update(32'h0000_0000, 1'b0);
        send_update(32'h7FFF_FFFF, 1'b1);
        in_ch.valid <= 1'b0;

        // Random phases; each starts from an idle block with new settings
        stamp_now = $urandom();
        phase_no  = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            randomize_config();
            if (phase_no % 6 == 2) begin
                // Keep offering items while the receiver holds off
                hold_off_req++;
                run_burst(64, 1'b1);
            end else begin
                run_burst($urandom_range(20, 120), $urandom_range(0, 3) == 0);
            end
            phase_no++;
        end

        settle();
        if (board.fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
